/* rtl/gtr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared constants, the 5x7 column font and the job record for the
// glyph text renderer.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int SCREEN_WIDTH = 128;  // 8..128
  localparam int PAGE_COUNT   = 8;    // 1..8

  localparam int GLYPH_COLS  = 5;
  localparam int CHAR_COLS   = 6;     // glyph plus gap column
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CODE_FIRST    = 8'd32;
  localparam logic [7:0] CODE_LAST     = 8'd128;
  localparam logic [7:0] CODE_FALLBACK = 8'd63;  // '?'

  localparam logic [7:0] MASK_BYTE    = 8'hFF;
  localparam logic [7:0] MASK_BIT0    = 8'h01;
  localparam logic [7:0] INV_TOP_ROWS = 8'h03;
  localparam logic [7:0] DATA_CLEAR   = 8'h00;
  localparam logic [7:0] DATA_SET     = 8'hFF;

  // column 0 in bits [39:32], column 4 in bits [7:0]
  localparam logic [39:0] FONT_ROM [97] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h1008081008, 40'h20383E3820,
    40'h020E3E0E02
  };

  typedef struct packed {
    logic [6:0] glyph_idx;
    logic [7:0] col0;
    logic [2:0] page;
    logic       inv;
    logic       next_ok;
    logic [2:0] ncols;
  } job_t;

  function automatic logic [6:0] font_col(input logic [6:0] idx, input logic [2:0] col);
    logic [39:0] row;
    row = FONT_ROM[idx];
    case (col)
      3'd0:    return row[38:32];
      3'd1:    return row[30:24];
      3'd2:    return row[22:16];
      3'd3:    return row[14:8];
      3'd4:    return row[6:0];
      default: return 7'd0;
    endcase
  endfunction

endpackage

/* rtl/glyph_text_renderer_5x7_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_renderer_5x7_top
// 5x7 font text renderer producing masked page-major framebuffer writes.
// ----------------------------------------------------------------------------
// Throughput: one write per cycle from the sequencer while the output is not
//   stalled; a drawing character makes 1..12 writes (up to 6 normal, up to 12 inverse), back to back.
// Input takes one character per cycle while the 4-entry job queue has room.
// Reset (rst_n low, synchronous): string inactive, cursor/page/mode zero,
//   queue and output stage empty.
module glyph_text_renderer_5x7_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_new_string,
  input  logic [7:0] in_start_col,
  input  logic [2:0] in_text_row,
  input  logic       in_inverse,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] out_write_address,
  output logic [7:0] out_write_data,
  output logic [7:0] out_write_mask,
  output logic       out_last_write
);
  import gtr_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t head_job;

  gtr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_new_string (in_new_string),
    .in_start_col  (in_start_col),
    .in_text_row   (in_text_row),
    .in_inverse    (in_inverse),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  gtr_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  gtr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .q_not_empty       (q_not_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_mask    (out_write_mask),
    .out_last_write    (out_last_write)
  );

endmodule

/* rtl/gtr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_front
// Takes characters, tracks the string cursor/page/mode and queues one
// render job per character that draws something.
// ----------------------------------------------------------------------------
module gtr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_code,
  input  logic              in_new_string,
  input  logic [7:0]        in_start_col,
  input  logic [2:0]        in_text_row,
  input  logic              in_inverse,
  input  logic              q_full,
  output logic              q_push,
  output gtr_pkg::job_t     q_job
);
  import gtr_pkg::*;

  logic [7:0] cursor_r, cursor_nxt;
  logic [2:0] page_r, page_nxt;
  logic       inv_r, inv_nxt;
  logic       active_r, active_nxt;

  logic       accept;
  logic [7:0] cursor_e;
  logic [2:0] page_e;
  logic       inv_e;
  logic       active_e;
  logic [7:0] remain;
  logic [2:0] ncols;
  logic [7:0] code_m;
  logic       draws;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cursor_e = in_new_string ? in_start_col : cursor_r;
    page_e   = in_new_string ? in_text_row  : page_r;
    inv_e    = in_new_string ? in_inverse   : inv_r;
    active_e = in_new_string ? ({1'b0, in_text_row} < 4'(PAGE_COUNT)) : active_r;

    remain = 8'(SCREEN_WIDTH) - cursor_e;
    ncols  = (remain >= 8'(CHAR_COLS)) ? 3'(CHAR_COLS) : remain[2:0];

    code_m = (in_char_code inside {[CODE_FIRST:CODE_LAST]}) ? in_char_code : CODE_FALLBACK;

    draws = (in_char_code != 8'd0) && active_e && (cursor_e < 8'(SCREEN_WIDTH));

    q_push          = accept && draws;
    q_job.glyph_idx = 7'(code_m - CODE_FIRST);
    q_job.col0      = cursor_e;
    q_job.page      = page_e;
    q_job.inv       = inv_e;
    q_job.next_ok   = ({1'b0, page_e} + 4'd1) < 4'(PAGE_COUNT);
    q_job.ncols     = ncols;

    cursor_nxt = cursor_r;
    page_nxt   = page_r;
    inv_nxt    = inv_r;
    active_nxt = active_r;
    if (accept) begin
      cursor_nxt = draws ? (cursor_e + {5'd0, ncols}) : cursor_e;
      page_nxt   = page_e;
      inv_nxt    = inv_e;
      active_nxt = (in_char_code == 8'd0) ? 1'b0 : active_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= 8'd0;
      page_r   <= 3'd0;
      inv_r    <= 1'b0;
      active_r <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      page_r   <= page_nxt;
      inv_r    <= inv_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

/* rtl/gtr_job_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_job_fifo
// Small job queue between the character front end and the write sequencer.
// ----------------------------------------------------------------------------
module gtr_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gtr_pkg::job_t push_job,
  input  logic          pop,
  output gtr_pkg::job_t head_job,
  output logic          full,
  output logic          not_empty
);
  import gtr_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/gtr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_back
// Write sequencer: walks the columns of one job, one framebuffer write per
// cycle unless the output stage is stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module gtr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gtr_pkg::job_t head_job,
  input  logic          q_not_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [9:0]    out_write_address,
  output logic [7:0]    out_write_data,
  output logic [7:0]    out_write_mask,
  output logic          out_last_write
);
  import gtr_pkg::*;

  job_t       job_r, job_nxt;
  logic       busy_r, busy_nxt;
  logic [2:0] col_r, col_nxt;
  logic       sub_r, sub_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [9:0] addr_r;
  logic [7:0] data_r;
  logic [7:0] mask_r;
  logic       last_r;

  logic        advance;
  logic        emit;
  logic        is_gap;
  logic        second;
  logic        last_col;
  logic        wr_last;
  logic [6:0]  g;
  logic [2:0]  page_sel;
  logic [7:0]  col_abs;
  logic [10:0] addr_full;
  logic [7:0]  wr_data;
  logic [7:0]  wr_mask;

  always_comb begin
    advance  = !out_valid_r || out_ready;
    emit     = busy_r && advance;
    is_gap   = (col_r == 3'(GLYPH_COLS));
    second   = job_r.inv && job_r.next_ok;
    last_col = (col_r == job_r.ncols - 3'd1);
    wr_last  = last_col && (sub_r || !second);
    g        = font_col(job_r.glyph_idx, col_r);

    page_sel  = sub_r ? job_r.page + 3'd1 : job_r.page;
    col_abs   = job_r.col0 + {5'd0, col_r};
    addr_full = 11'(page_sel) * 11'(SCREEN_WIDTH) + 11'(col_abs);

    wr_mask = sub_r ? MASK_BIT0 : MASK_BYTE;
    if (!job_r.inv) begin
      wr_data = is_gap ? DATA_CLEAR : {1'b0, g};
    end else if (!sub_r) begin
      // inverted glyph moved down two rows, bar on the top two rows
      wr_data = is_gap ? DATA_SET : (~{g[5:0], 2'b00} | INV_TOP_ROWS);
    end else begin
      wr_data = is_gap ? MASK_BIT0 : {7'd0, ~g[6]};
    end

    q_pop = q_not_empty && (!busy_r || (emit && wr_last));

    job_nxt  = job_r;
    busy_nxt = busy_r;
    col_nxt  = col_r;
    sub_nxt  = sub_r;
    if (q_pop) begin
      job_nxt  = head_job;
      busy_nxt = 1'b1;
      col_nxt  = 3'd0;
      sub_nxt  = 1'b0;
    end else if (emit) begin
      if (wr_last) begin
        busy_nxt = 1'b0;
      end else if (second && !sub_r) begin
        sub_nxt = 1'b1;
      end else begin
        sub_nxt = 1'b0;
        col_nxt = col_r + 3'd1;
      end
    end

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    col_r <= col_nxt;
    sub_r <= sub_nxt;
    if (emit) begin
      addr_r <= addr_full[9:0];
      data_r <= wr_data;
      mask_r <= wr_mask;
      last_r <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = addr_r;
  assign out_write_data    = data_r;
  assign out_write_mask    = mask_r;
  assign out_last_write    = last_r;

endmodule

/* rtl/gtr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_checker
// Port-level checks on the renderer's write channel.
// ----------------------------------------------------------------------------
module gtr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_write_address,
  input logic [7:0] out_write_data,
  input logic [7:0] out_write_mask,
  input logic       out_last_write
);
  import gtr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_address)
      && $stable(out_write_data) && $stable(out_write_mask) && $stable(out_last_write))
    else $error("write item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("write item valid right after reset");

  a_mask_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_mask == MASK_BYTE || out_write_mask == MASK_BIT0))
    else $error("illegal write mask");

  a_bit0_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_mask == MASK_BIT0 |-> out_write_data[7:1] == 7'd0)
    else $error("next-page write carries data outside bit 0");

endmodule

bind glyph_text_renderer_5x7_top gtr_checker u_gtr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_write_address (out_write_address),
  .out_write_data    (out_write_data),
  .out_write_mask    (out_write_mask),
  .out_last_write    (out_last_write)
);

/* dv/glyph_text_renderer_5x7_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_renderer_5x7_top_tb
// Self-checking bench for the 5x7 text renderer. Drives text strings through
// the character channel under random bursts and output stalls. Predicts every
// masked framebuffer write in a scoreboard and checks the writes in order.
// ----------------------------------------------------------------------------
module glyph_text_renderer_5x7_top_tb;
  import gtr_pkg::*;

  typedef struct packed {
    logic [9:0] addr;
    logic [7:0] data;
    logic [7:0] mask;
    logic       last_wr;
  } fb_write_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT, RX_BEAT} rx_mode_t;

  // column 0 in bits [39:32], column 4 in bits [7:0]
  localparam logic [39:0] GLYPHS [97] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h20383E3820,
    40'h020E3E0E02
  };

  class fb_scoreboard;
    fb_write_t  pending_writes[$];
    logic [7:0] cur_col;
    logic [2:0] cur_page;
    logic       inv_on;
    logic       active;
    int         errors;
    int         writes_checked;
    int         chars_seen;
    int         inv_strings;

    function new();
      cur_col = '0;
      cur_page = '0;
      inv_on = 1'b0;
      active = 1'b0;
      errors = 0;
      writes_checked = 0;
      chars_seen = 0;
      inv_strings = 0;
    endfunction

    function void push_write(int page, int col, logic [7:0] d, logic [7:0] m);
      fb_write_t w;
      w.addr = 10'(page * SCREEN_WIDTH + col);
      w.data = d;
      w.mask = m;
      w.last_wr = 1'b0;
      pending_writes.push_back(w);
    endfunction

    // returns the number of writes this character causes
    function int note_char(logic [7:0] code, logic ns, logic [7:0] col, logic [2:0] row,
                           logic inv);
      int         idx;
      int         c;
      int         start_n;
      logic [6:0] g;
      logic [15:0] sh;
      logic       nxt;
      start_n = pending_writes.size();
      chars_seen++;
      if (ns) begin
        cur_col = col;
        cur_page = row;
        inv_on = inv;
        active = (int'(row) < PAGE_COUNT);
        if (inv) inv_strings++;
      end
      if (code == 8'd0) begin
        active = 1'b0;
        return 0;
      end
      if (!active || int'(cur_col) >= SCREEN_WIDTH) return 0;
      if (code < CODE_FIRST || code > CODE_LAST) idx = int'(CODE_FALLBACK - CODE_FIRST);
      else idx = int'(code - CODE_FIRST);
      nxt = (int'(cur_page) + 1) < PAGE_COUNT;
      for (c = 0; c < GLYPH_COLS && int'(cur_col) < SCREEN_WIDTH; c++) begin
        g = GLYPHS[idx][38 - 8 * c -: 7];
        if (inv_on) begin
          // inverted glyph moved down two rows; row 6 spills into next page bit 0
          sh = ~({9'd0, g} << 2);
          push_write(int'(cur_page), int'(cur_col), sh[7:0] | INV_TOP_ROWS, MASK_BYTE);
          if (nxt)
            push_write(int'(cur_page) + 1, int'(cur_col), {7'd0, sh[8]}, MASK_BIT0);
        end else begin
          push_write(int'(cur_page), int'(cur_col), {1'b0, g}, MASK_BYTE);
        end
        cur_col++;
      end
      if (int'(cur_col) < SCREEN_WIDTH) begin
        if (inv_on) begin
          push_write(int'(cur_page), int'(cur_col), DATA_SET, MASK_BYTE);
          if (nxt) push_write(int'(cur_page) + 1, int'(cur_col), MASK_BIT0, MASK_BIT0);
        end else begin
          push_write(int'(cur_page), int'(cur_col), DATA_CLEAR, MASK_BYTE);
        end
        cur_col++;
      end
      if (pending_writes.size() > start_n)
        pending_writes[pending_writes.size() - 1].last_wr = 1'b1;
      return pending_writes.size() - start_n;
    endfunction

    function void check_write(fb_write_t act);
      fb_write_t exp_w;
      if (pending_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected write addr=%0d data=%02h mask=%02h last=%0d",
                 $time, act.addr, act.data, act.mask, act.last_wr);
        return;
      end
      exp_w = pending_writes.pop_front();
      writes_checked++;
      if (act.addr !== exp_w.addr) begin
        errors++;
        $display("%0t: write_address expected %0d actual %0d", $time, exp_w.addr, act.addr);
      end
      if (act.data !== exp_w.data) begin
        errors++;
        $display("%0t: write_data expected %02h actual %02h (addr %0d)",
                 $time, exp_w.data, act.data, exp_w.addr);
      end
      if (act.mask !== exp_w.mask) begin
        errors++;
        $display("%0t: write_mask expected %02h actual %02h (addr %0d)",
                 $time, exp_w.mask, act.mask, exp_w.addr);
      end
      if (act.last_wr !== exp_w.last_wr) begin
        errors++;
        $display("%0t: last_write expected %0d actual %0d (addr %0d)",
                 $time, exp_w.last_wr, act.last_wr, exp_w.addr);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = '0;
  logic       in_new_string = 1'b0;
  logic [7:0] in_start_col = '0;
  logic [2:0] in_text_row = '0;
  logic       in_inverse = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [9:0] out_write_address;
  logic [7:0] out_write_data;
  logic [7:0] out_write_mask;
  logic       out_last_write;

  fb_scoreboard sb;
  int       accepted_chars = 0;
  int       drawing_chars = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_phase = 0;

  glyph_text_renderer_5x7_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_new_string     (in_new_string),
    .in_start_col      (in_start_col),
    .in_text_row       (in_text_row),
    .in_inverse        (in_inverse),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_mask    (out_write_mask),
    .out_last_write    (out_last_write)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        accepted_chars++;
        if (sb.note_char(in_char_code, in_new_string, in_start_col, in_text_row,
                         in_inverse) > 0)
          drawing_chars++;
      end
      if (out_valid && out_ready)
        sb.check_write({out_write_address, out_write_data, out_write_mask, out_last_write});
    end
  end

  // receiver back-pressure: four random modes, each held for a random run
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    rx_phase++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
        RX_TIGHT: out_ready <= ($urandom_range(0, 3) == 0);
        default:  out_ready <= (rx_phase % 5 != 0) && (rx_phase % 7 != 3);
      endcase
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_char(input logic [7:0] code, input logic ns, input logic [7:0] col,
                            input logic [2:0] row, input logic inv);
    int seen;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_char_code = code;
    in_new_string = ns;
    in_start_col = col;
    in_text_row = row;
    in_inverse = inv;
    in_valid = 1'b1;
    seen = accepted_chars;
    do @(negedge clk); while (accepted_chars == seen);
  endtask

  task automatic drain_writes();
    in_valid = 1'b0;
    while (sb.pending_writes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_code(input bit noisy);
    int r;
    r = $urandom_range(0, 19);
    if (noisy) return (r < 3) ? 8'd0 : 8'($urandom_range(0, 255));
    if (r == 0) return 8'($urandom_range(1, 31));
    if (r == 1) return 8'($urandom_range(129, 255));
    return 8'($urandom_range(32, 128));
  endfunction

  task automatic run_random_strings();
    bit         noisy;
    bit         drained_mid;
    int         len;
    int         k;
    logic [7:0] col;
    logic [2:0] row;
    logic       inv;
    logic       ns;
    drained_mid = 1'b0;
    while (accepted_chars < 270) begin
      noisy = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
        0:       col = 8'($urandom_range(128, 255));
        1, 2:    col = 8'($urandom_range(100, 127));
        default: col = 8'($urandom_range(0, 127));
      endcase
      row = 3'($urandom_range(0, 7));
      inv = 1'($urandom_range(0, 1));
      len = $urandom_range(1, 12);
      for (k = 0; k < len; k++) begin
        ns = (k == 0) && !(noisy && $urandom_range(0, 1));
        if (k == 0) drive_char(pick_code(noisy), ns, col, row, inv);
        else drive_char(pick_code(noisy), 1'b0, 8'($urandom_range(0, 255)),
                        3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
      if (!drained_mid && accepted_chars >= 135) begin
        drain_writes();
        drained_mid = 1'b1;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // character with no string open
    drive_char(8'd65, 1'b0, 8'd0, 3'd0, 1'b0);
    // normal string, font range edges and fallback codes
    drive_char(8'd65, 1'b1, 8'd0, 3'd0, 1'b0);
    drive_char(8'd122, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd128, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd127, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd32, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd31, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd255, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd1, 1'b0, 8'd0, 3'd0, 1'b0);
    // inverse on the last page: no next-page writes
    drive_char(8'd87, 1'b1, 8'd0, 3'd7, 1'b1);
    drive_char(8'd126, 1'b0, 8'd0, 3'd0, 1'b0);
    // inverse clipping at the right edge, then cursor parked at width
    drive_char(8'd72, 1'b1, 8'd122, 3'd0, 1'b1);
    drive_char(8'd73, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd74, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd66, 1'b1, 8'd125, 3'd2, 1'b0);
    drive_char(8'd67, 1'b0, 8'd0, 3'd0, 1'b0);
    // start column at or beyond width
    drive_char(8'd65, 1'b1, 8'd200, 3'd5, 1'b0);
    drive_char(8'd65, 1'b1, 8'd128, 3'd5, 1'b1);
    // NUL opening a string, and NUL ending one
    drive_char(8'd0, 1'b1, 8'd10, 3'd4, 1'b0);
    drive_char(8'd65, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd103, 1'b1, 8'd60, 3'd3, 1'b1);
    drive_char(8'd0, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd65, 1'b0, 8'd0, 3'd0, 1'b0);
    drive_char(8'd88, 1'b1, 8'd127, 3'd6, 1'b0);
    drive_char(8'd48, 1'b1, 8'd255, 3'd6, 1'b1);
    drain_writes();

    run_random_strings();

    drain_writes();
    repeat (16) @(negedge clk);
    $display("run covered %0d characters (%0d inverse strings), %0d framebuffer writes checked",
             sb.chars_seen, sb.inv_strings, sb.writes_checked);
    if (sb.errors == 0 && sb.pending_writes.size() == 0) begin
      $display("glyph_text_renderer_5x7_top_tb: clean");
    end else begin
      $display("%0t: %0d mismatches, %0d writes never seen", $time, sb.errors,
               sb.pending_writes.size());
      $display("glyph_text_renderer_5x7_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("glyph_text_renderer_5x7_top_tb: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/gtr_pkg.sv
rtl/gtr_front.sv
rtl/gtr_job_fifo.sv
rtl/gtr_back.sv
rtl/glyph_text_renderer_5x7_top.sv
rtl/gtr_checker.sv
dv/glyph_text_renderer_5x7_top_tb.sv
